// ===== rtl/multi_task_heartbeat_watchdog_macros.svh =====
// Assertion macros used by the watchdog top module.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTHW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("watchdog assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MTHW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("watchdog assertion failed");

`endif

// ===== rtl/mthw_pkg.sv =====
package mthw_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MASK_W    = 8;

   localparam logic [31:0] FALLBACK_TIMEOUT_MS = 32'd8000;

   localparam logic [1:0] OP_REGISTER  = 2'd0;
   localparam logic [1:0] OP_HEARTBEAT = 2'd1;
   localparam logic [1:0] OP_CHECK     = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_ENABLE  = 2'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  task_index;
      logic [31:0] timeout_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        healthy;
      logic [7:0]  newly_failed;
      logic [7:0]  failed_mask;
      logic        restart_request;
   } rsp_type;

   typedef struct packed {
      logic              arm;
      logic              beat;
      logic              fail;
      logic [SLOT_W-1:0] index;
      logic [31:0]       timeout_ms;
      logic [31:0]       now_ms;
   } slot_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_REPORT
   } state_type;

endpackage

// ===== rtl/multi_task_heartbeat_watchdog.sv =====
// After the accepting edge the FSM steps through UPDATE, SCAN and REPORT: UPDATE applies a
// register or heartbeat to its slot, then in SCAN a single subtract-and-compare unit visits
// the slots one per cycle to find overdue ones, and REPORT presents the result. busy stays
// high from the cycle after start until the result cycle ends and then falls while the FSM
// is idle, so a new item can be taken only once the last one's result has been shown. The
// result is shown for exactly one cycle with rsp_valid and cannot be held off, so it must
// be captured then.
// Configuration writes are always accepted and should only be made while busy is low.
`include "multi_task_heartbeat_watchdog_macros.svh"

module multi_task_heartbeat_watchdog (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  mthw_pkg::req_type                  req_item,
   output logic                               rsp_valid,
   output mthw_pkg::rsp_type                  rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mthw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);

   mthw_pkg::state_type state_ff;
   mthw_pkg::state_type state_in;
   mthw_pkg::req_type   req_ff;
   logic [mthw_pkg::SLOT_W-1:0] cnt_ff;
   logic [mthw_pkg::SLOT_W-1:0] cnt_in;
   logic                        ok_ff;
   logic                        ok_in;
   logic [mthw_pkg::MASK_W-1:0] fresh_ff;
   logic [mthw_pkg::MASK_W-1:0] fresh_in;
   logic [31:0]                 dflt_ff;
   logic                        restart_ff;

   mthw_pkg::slot_wr_type       slot_wr;
   logic [31:0]                 rd_last_beat;
   logic [31:0]                 rd_timeout;
   logic                        rd_registered;
   logic                        rd_failed;
   logic [mthw_pkg::NUM_SLOTS-1:0] failed_vec;
   logic [mthw_pkg::MASK_W-1:0] failed_mask;

   logic [31:0] elapsed;
   logic        overdue;
   logic        idx_ok;
   logic        scan_last;
   logic        accept;
   logic [31:0] dflt_eff;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign idx_ok    = int'(req_ff.task_index) < mthw_pkg::NUM_SLOTS;
   assign scan_last = cnt_ff == mthw_pkg::SLOT_W'(mthw_pkg::NUM_SLOTS - 1);
   assign elapsed   = req_ff.now_ms - rd_last_beat;
   assign overdue   = elapsed > rd_timeout;
   assign dflt_eff  = (dflt_ff != 32'd0) ? dflt_ff : mthw_pkg::FALLBACK_TIMEOUT_MS;

   mthw_slot_file u_slots (
      .clock         (clock),
      .reset         (reset),
      .wr            (slot_wr),
      .rd_index      (cnt_ff),
      .rd_last_beat  (rd_last_beat),
      .rd_timeout    (rd_timeout),
      .rd_registered (rd_registered),
      .rd_failed     (rd_failed),
      .failed_vec    (failed_vec)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mthw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mthw_pkg::ST_UPDATE;
            end
         end
         mthw_pkg::ST_UPDATE: state_in = mthw_pkg::ST_SCAN;
         mthw_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = mthw_pkg::ST_REPORT;
            end
         end
         mthw_pkg::ST_REPORT: state_in = mthw_pkg::ST_IDLE;
         default: state_in = mthw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy               = 1'b1;
      rsp_valid          = 1'b0;
      cnt_in             = cnt_ff;
      ok_in              = ok_ff;
      fresh_in           = fresh_ff;
      slot_wr.arm        = 1'b0;
      slot_wr.beat       = 1'b0;
      slot_wr.fail       = 1'b0;
      slot_wr.index      = cnt_ff;
      slot_wr.timeout_ms = (req_ff.timeout_ms != 32'd0) ? req_ff.timeout_ms : dflt_eff;
      slot_wr.now_ms     = req_ff.now_ms;
      case (state_ff)
         mthw_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         mthw_pkg::ST_UPDATE: begin
            slot_wr.index = mthw_pkg::SLOT_W'(req_ff.task_index);
            slot_wr.arm   = idx_ok && (req_ff.opcode == mthw_pkg::OP_REGISTER);
            slot_wr.beat  = idx_ok && (req_ff.opcode == mthw_pkg::OP_HEARTBEAT);
            cnt_in        = '0;
            ok_in         = 1'b1;
            fresh_in      = '0;
         end
         mthw_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + mthw_pkg::SLOT_W'(1);
            if (rd_registered && overdue) begin
               ok_in = 1'b0;
            end
            if ((req_ff.opcode == mthw_pkg::OP_CHECK) && rd_registered && !rd_failed
                && overdue) begin
               slot_wr.fail = 1'b1;
               if (int'(cnt_ff) < mthw_pkg::MASK_W) begin
                  fresh_in = fresh_ff | (mthw_pkg::MASK_W'(1) << cnt_ff);
               end
            end
         end
         mthw_pkg::ST_REPORT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      failed_mask = '0;
      for (int i = 0; i < mthw_pkg::MASK_W; i++) begin
         if (i < mthw_pkg::NUM_SLOTS) begin
            failed_mask[i] = failed_vec[i % mthw_pkg::NUM_SLOTS];
         end
      end
   end

   assign rsp_item.healthy         = ok_ff;
   assign rsp_item.newly_failed    = fresh_ff;
   assign rsp_item.failed_mask     = failed_mask;
   assign rsp_item.restart_request = restart_ff && (fresh_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mthw_pkg::ST_IDLE;
         dflt_ff    <= mthw_pkg::FALLBACK_TIMEOUT_MS;
         restart_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mthw_pkg::CSR_DEFAULT_TIMEOUT: dflt_ff    <= csr_wdata;
               mthw_pkg::CSR_RESTART_ENABLE:  restart_ff <= csr_wdata[0];
               default: dflt_ff <= dflt_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      cnt_ff   <= cnt_in;
      ok_ff    <= ok_in;
      fresh_ff <= fresh_in;
   end

   `MTHW_ASSERT_NEXT(a_accept_goes_busy, clock, reset, accept, busy)
   `MTHW_ASSERT_NEXT(a_single_cycle_result, clock, reset, rsp_valid, !rsp_valid)
   `MTHW_ASSERT_SAME(a_new_fail_in_mask, clock, reset, rsp_valid,
      (rsp_item.newly_failed & ~rsp_item.failed_mask) == 8'd0)
   `MTHW_ASSERT_SAME(a_fresh_only_on_check, clock, reset,
      rsp_valid && (req_ff.opcode != mthw_pkg::OP_CHECK), rsp_item.newly_failed == 8'd0)
   `MTHW_ASSERT_SAME(a_new_fail_unhealthy, clock, reset,
      rsp_valid && (rsp_item.newly_failed != 8'd0), !rsp_item.healthy)

endmodule

// ===== rtl/mthw_slot_file.sv =====
module mthw_slot_file (
   input  logic                          clock,
   input  logic                          reset,
   input  mthw_pkg::slot_wr_type         wr,
   input  logic [mthw_pkg::SLOT_W-1:0]   rd_index,
   output logic [31:0]                   rd_last_beat,
   output logic [31:0]                   rd_timeout,
   output logic                          rd_registered,
   output logic                          rd_failed,
   output logic [mthw_pkg::NUM_SLOTS-1:0] failed_vec
);

   logic [31:0] last_beat_ff [mthw_pkg::NUM_SLOTS];
   logic [31:0] timeout_ff   [mthw_pkg::NUM_SLOTS];
   logic [mthw_pkg::NUM_SLOTS-1:0] registered_ff;
   logic [mthw_pkg::NUM_SLOTS-1:0] registered_in;
   logic [mthw_pkg::NUM_SLOTS-1:0] failed_ff;
   logic [mthw_pkg::NUM_SLOTS-1:0] failed_in;
   logic beat_ok;

   assign beat_ok = wr.beat && registered_ff[wr.index];

   always_comb begin
      registered_in = registered_ff;
      failed_in     = failed_ff;
      if (wr.arm) begin
         registered_in[wr.index] = 1'b1;
         failed_in[wr.index]     = 1'b0;
      end else if (beat_ok) begin
         failed_in[wr.index] = 1'b0;
      end else if (wr.fail) begin
         failed_in[wr.index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         failed_ff     <= '0;
      end else begin
         registered_ff <= registered_in;
         failed_ff     <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.arm) begin
         timeout_ff[wr.index]   <= wr.timeout_ms;
         last_beat_ff[wr.index] <= wr.now_ms;
      end else if (beat_ok) begin
         last_beat_ff[wr.index] <= wr.now_ms;
      end
   end

   assign rd_last_beat  = last_beat_ff[rd_index];
   assign rd_timeout    = timeout_ff[rd_index];
   assign rd_registered = registered_ff[rd_index];
   assign rd_failed     = failed_ff[rd_index];
   assign failed_vec    = failed_ff;

endmodule

// ===== sim/tb_multi_task_heartbeat_watchdog.sv =====
module tb_multi_task_heartbeat_watchdog;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 230;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   mthw_pkg::req_type    req_item = '0;
   logic                 rsp_valid;
   mthw_pkg::rsp_type    rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [mthw_pkg::CSR_IDX_W-1:0] csr_index = mthw_pkg::CSR_DEFAULT_TIMEOUT;
   logic [31:0]          csr_wdata = '0;

   mthw_pkg::req_type pending_items[$];
   mthw_pkg::rsp_type expected_status[$];
   logic        req_taken = 1'b0;
   int          gap_pct = 7;
   int          error_count = 0;
   int          items_accepted = 0;
   int          results_checked = 0;
   int          failing_checks = 0;
   int          restart_pulses = 0;
   int          cycle_count = 0;

   logic        slot_armed [8];
   logic        slot_tripped [8];
   logic [31:0] slot_beat_ms [8];
   logic [31:0] slot_timeout_ms [8];
   logic [31:0] cfg_default_ms = mthw_pkg::FALLBACK_TIMEOUT_MS;
   logic        cfg_restart = 1'b0;

   multi_task_heartbeat_watchdog u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic slot_overdue(int s, logic [31:0] now_ms);
      logic [31:0] elapsed;
      elapsed = now_ms - slot_beat_ms[s];
      return elapsed > slot_timeout_ms[s];
   endfunction

   function automatic mthw_pkg::rsp_type watchdog_predict(mthw_pkg::req_type r);
      mthw_pkg::rsp_type st;
      logic [31:0]       dflt;
      st = '0;
      st.healthy = 1'b1;
      case (r.opcode)
         mthw_pkg::OP_REGISTER: begin
            dflt = (cfg_default_ms != 0) ? cfg_default_ms : mthw_pkg::FALLBACK_TIMEOUT_MS;
            slot_timeout_ms[r.task_index] = (r.timeout_ms != 0) ? r.timeout_ms : dflt;
            slot_beat_ms[r.task_index]    = r.now_ms;
            slot_armed[r.task_index]      = 1'b1;
            slot_tripped[r.task_index]    = 1'b0;
         end
         mthw_pkg::OP_HEARTBEAT: begin
            if (slot_armed[r.task_index]) begin
               slot_beat_ms[r.task_index] = r.now_ms;
               slot_tripped[r.task_index] = 1'b0;
            end
         end
         mthw_pkg::OP_CHECK: begin
            for (int s = 0; s < 8; s++) begin
               if (slot_armed[s] && !slot_tripped[s] && slot_overdue(s, r.now_ms)) begin
                  slot_tripped[s]    = 1'b1;
                  st.newly_failed[s] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      for (int s = 0; s < 8; s++) begin
         if (slot_armed[s] && slot_overdue(s, r.now_ms))
            st.healthy = 1'b0;
         st.failed_mask[s] = slot_tripped[s];
      end
      st.restart_request = cfg_restart && (st.newly_failed != 0);
      return st;
   endfunction

   always @(negedge clock) begin
      if (reset)
         start <= 1'b0;
      else if (start && !req_taken)
         ;
      else if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
         req_item <= pending_items.pop_front();
         start    <= 1'b1;
      end else
         start <= 1'b0;
   end

   always @(posedge clock) begin
      mthw_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         for (int s = 0; s < 8; s++) begin
            slot_armed[s]   = 1'b0;
            slot_tripped[s] = 1'b0;
         end
      end else begin
         if (rsp_valid) begin
            results_checked++;
            if (rsp_item.newly_failed != 0)
               failing_checks++;
            if (rsp_item.restart_request)
               restart_pulses++;
            if (expected_status.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result %h with no item outstanding", $time,
                        rsp_item);
            end else begin
               want = expected_status.pop_front();
               if (rsp_item.healthy !== want.healthy) begin
                  error_count++;
                  $display("%0t: healthy expected %b actual %b", $time, want.healthy,
                           rsp_item.healthy);
               end
               if (rsp_item.newly_failed !== want.newly_failed) begin
                  error_count++;
                  $display("%0t: newly_failed expected %h actual %h", $time,
                           want.newly_failed, rsp_item.newly_failed);
               end
               if (rsp_item.failed_mask !== want.failed_mask) begin
                  error_count++;
                  $display("%0t: failed_mask expected %h actual %h", $time,
                           want.failed_mask, rsp_item.failed_mask);
               end
               if (rsp_item.restart_request !== want.restart_request) begin
                  error_count++;
                  $display("%0t: restart_request expected %b actual %b", $time,
                           want.restart_request, rsp_item.restart_request);
               end
            end
         end
         if (start && !busy) begin
            items_accepted++;
            expected_status.push_back(watchdog_predict(req_item));
         end
         req_taken <= start && !busy;
         if (csr_valid && csr_ready) begin
            if (csr_index == mthw_pkg::CSR_DEFAULT_TIMEOUT)
               cfg_default_ms = csr_wdata;
            else if (csr_index == mthw_pkg::CSR_RESTART_ENABLE)
               cfg_restart = csr_wdata[0];
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped by the cycle limit", $time);
         $display("tb_multi_task_heartbeat_watchdog failed");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] op, logic [2:0] idx, logic [31:0] tmo,
                            logic [31:0] now_ms);
      mthw_pkg::req_type r;
      r.opcode     = op;
      r.task_index = idx;
      r.timeout_ms = tmo;
      r.now_ms     = now_ms;
      pending_items.push_back(r);
   endtask

   task automatic wait_drained();
      int quiet;
      quiet = 0;
      while (quiet < 2) begin
         @(negedge clock);
         if (pending_items.size() != 0 || start || busy || expected_status.size() != 0)
            quiet = 0;
         else
            quiet++;
      end
   endtask

   task automatic csr_write(logic [mthw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] wall_ms;
      logic [31:0] dflt;
      logic        restart;
      int          step_max;
      int          pick;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd0);
      push_item(OP_RESERVED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(mthw_pkg::OP_HEARTBEAT, 3'd5, 32'd123, 32'd50);
      push_item(mthw_pkg::OP_REGISTER, 3'd0, 32'd0, 32'd0);
      push_item(mthw_pkg::OP_REGISTER, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(mthw_pkg::OP_REGISTER, 3'd1, 32'd1, 32'd100);
      push_item(mthw_pkg::OP_CHECK, 3'd3, 32'd0, 32'd101);
      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd102);
      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd103);
      push_item(mthw_pkg::OP_HEARTBEAT, 3'd1, 32'd0, 32'd103);
      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd8001);
      push_item(mthw_pkg::OP_REGISTER, 3'd0, 32'd5, 32'd8001);
      push_item(mthw_pkg::OP_REGISTER, 3'd2, 32'd10, 32'hFFFF_FFF8);
      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd1);
      push_item(mthw_pkg::OP_CHECK, 3'd0, 32'd0, 32'd3);
      push_item(mthw_pkg::OP_HEARTBEAT, 3'd2, 32'd0, 32'd0);
      push_item(OP_RESERVED, 3'd0, 32'd0, 32'd5);
      push_item(mthw_pkg::OP_HEARTBEAT, 3'd7, 32'hFFFF_FFFF, 32'd0);
      push_item(mthw_pkg::OP_CHECK, 3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (12) @(posedge clock);
         case (p)
            0: begin dflt = 32'd0;          restart = 1'b1; end
            1: begin dflt = 32'd1;          restart = 1'b0; end
            2: begin dflt = 32'hFFFF_FFFF;  restart = 1'b1; end
            3: begin dflt = 32'd8000;       restart = 1'b0; end
            default: begin
               dflt    = $urandom_range(300, 1);
               restart = 1'($urandom_range(1));
            end
         endcase
         csr_write(mthw_pkg::CSR_DEFAULT_TIMEOUT, dflt);
         csr_write(mthw_pkg::CSR_RESTART_ENABLE, {31'($urandom), restart});
         gap_pct  = (p == 3) ? 0 : 7;
         step_max = 4 + 6 * p;
         wall_ms  = (p % 2 == 0) ? 32'hFFFF_FF00 : $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            wall_ms = wall_ms + $urandom_range(step_max, 0);
            pick    = $urandom_range(99);
            if (pick < 15) begin
               case ($urandom_range(9))
                  0, 1, 2: push_item(mthw_pkg::OP_REGISTER, 3'($urandom), 32'd0, wall_ms);
                  3:       push_item(mthw_pkg::OP_REGISTER, 3'($urandom), $urandom, wall_ms);
                  default: push_item(mthw_pkg::OP_REGISTER, 3'($urandom),
                                     $urandom_range(150, 1), wall_ms);
               endcase
            end else if (pick < 50)
               push_item(mthw_pkg::OP_HEARTBEAT, 3'($urandom), $urandom, wall_ms);
            else if (pick < 88)
               push_item(mthw_pkg::OP_CHECK, 3'($urandom), $urandom, wall_ms);
            else if (pick < 92)
               push_item(OP_RESERVED, 3'($urandom), $urandom, $urandom);
            else begin
               push_item(2'($urandom), 3'($urandom), $urandom, $urandom);
               if ($urandom_range(3) == 0)
                  wall_ms = $urandom;
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Ran %0d items over %0d register settings, %0d results checked.",
               items_accepted, NUM_PHASES, results_checked);
      $display("Checks that found new failures: %0d, restart pulses seen: %0d.",
               failing_checks, restart_pulses);
      if (error_count == 0)
         $display("tb_multi_task_heartbeat_watchdog passed");
      else
         $display("tb_multi_task_heartbeat_watchdog failed");
      $finish;
   end

endmodule
